/* design/rhd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared types, codes and helpers of the range-hold drive controller.
// ----------------------------------------------------------------------------
package rhd_pkg;

  localparam int CALIB_SAMPLES = 4;
  localparam int DRIVE_MAX     = 255;

  localparam int DIST_W  = 15;
  localparam int SUM_W   = DIST_W + $clog2(CALIB_SAMPLES);
  localparam int CNT_W   = $clog2(CALIB_SAMPLES + 1);
  localparam int DRV_W   = 9;

  // echo_us * 17 / 50 == (echo_us * 17 * ceil(2^27 / 50)) >> 27 for 16-bit echo
  localparam int          DIST_SHIFT = 27;
  localparam logic [25:0] DIST_RECIP = 26'd45634035;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_LC_C    = 8'h63;
  localparam logic [7:0] CH_UC_C    = 8'h43;
  localparam logic [7:0] CH_LC_R    = 8'h72;
  localparam logic [7:0] CH_UC_R    = 8'h52;

  localparam logic [1:0] CFG_TRACK_SPEED = 2'd0;
  localparam logic [1:0] CFG_BAND_TOL    = 2'd1;
  localparam logic [1:0] CFG_SPIN_SPEED  = 2'd2;
  localparam logic [1:0] CFG_GYRO_GAIN   = 2'd3;

  typedef enum logic [2:0] {
    MODE_STANDBY = 3'd0,
    MODE_RELAY   = 3'd1,
    MODE_CALIB   = 3'd2,
    MODE_TRACK   = 3'd3,
    MODE_ROTATE  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_STANDBY = 3'd1,
    CMD_RELAY   = 3'd2,
    CMD_TRACK   = 3'd3,
    CMD_CALIB   = 3'd4,
    CMD_ROTATE  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    CLS_OTHER   = 2'd0,
    CLS_NEWLINE = 2'd1,
    CLS_SPACE   = 2'd2
  } cls_e;

  typedef struct packed {
    logic [7:0]  track_speed;
    logic [11:0] band_tol;
    logic [7:0]  spin_speed;
    logic [15:0] gyro_gain;
  } rhd_cfg_t;

  // one classified item as handed from the front end to the back end
  typedef struct packed {
    logic                    op;
    cls_e                    cls;
    cmd_e                    cmd;
    logic [DIST_W-1:0]       dist_mm;
    logic signed [DRV_W-1:0] fwd_a;
    logic signed [DRV_W-1:0] fwd_b;
    logic signed [DRV_W-1:0] bwd_a;
    logic signed [DRV_W-1:0] bwd_b;
  } rhd_item_t;

  typedef struct packed {
    logic                    report;
    logic                    ack;
    logic [DIST_W-1:0]       target;
    logic [DIST_W-1:0]       dist_mm;
    logic                    on;
    logic signed [DRV_W-1:0] drv_b;
    logic signed [DRV_W-1:0] drv_a;
    logic [2:0]              mode;
  } rhd_result_t;

  function automatic logic signed [DRV_W-1:0] clamp_drive(input logic signed [15:0] v);
    logic signed [15:0] lim;
    lim = 16'(DRIVE_MAX);
    if (v > lim) return DRV_W'(lim);
    if (v < -lim) return DRV_W'(-lim);
    return DRV_W'(v);
  endfunction

endpackage

/* design/rhd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_front
// Accepts items, classifies host bytes, scales the echo to millimetres and
// precomputes the four saturated track drives from the gyro product.
// ----------------------------------------------------------------------------
module rhd_front import rhd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rhd_cfg_t    cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  host_byte_i,
  input  logic [15:0] echo_us_i,
  input  logic [15:0] gyro_rate_i,
  output logic        q_wr_o,
  output rhd_item_t   q_item_o,
  input  logic        q_full_i
);

  // stage 1: classify and multiply
  logic                   v1_q;
  logic                   op1_q;
  cls_e                   cls1_q;
  cmd_e                   cmd1_q;
  logic [DIST_W-1:0]      dist1_q;
  logic signed [32:0]     prod1_q;
  // stage 2: track drive candidates
  logic                   v2_q;
  rhd_item_t              item2_q;

  logic                   ready1, ready2;
  cls_e                   cls_d;
  cmd_e                   cmd_d;
  logic [41:0]            dmul;
  logic signed [32:0]     prod_d;
  logic signed [34:0]     spd, prod35;
  rhd_item_t              item2_d;

  assign ready2     = !v2_q || !q_full_i;
  assign ready1     = !v1_q || ready2;
  assign in_ready_o = ready1;
  assign q_wr_o     = v2_q && !q_full_i;
  assign q_item_o   = item2_q;

  always_comb begin
    cls_d = CLS_OTHER;
    if (host_byte_i == CH_NEWLINE) cls_d = CLS_NEWLINE;
    else if (host_byte_i == CH_SPACE) cls_d = CLS_SPACE;
    case (host_byte_i)
      CH_ZERO:          cmd_d = CMD_STANDBY;
      CH_ONE:           cmd_d = CMD_RELAY;
      CH_TWO:           cmd_d = CMD_TRACK;
      CH_LC_C, CH_UC_C: cmd_d = CMD_CALIB;
      CH_LC_R, CH_UC_R: cmd_d = CMD_ROTATE;
      default:          cmd_d = CMD_NONE;
    endcase
  end

  // DIST_RECIP already carries the factor 17
  assign dmul   = 42'(echo_us_i) * 42'(DIST_RECIP);
  assign prod_d = $signed({1'b0, cfg_i.gyro_gain}) * $signed(gyro_rate_i);

  // (+-s * 2^20 +- P) / 2^20, rounded toward zero, then saturated
  function automatic logic signed [DRV_W-1:0] scale_drive(input logic signed [34:0] v);
    logic signed [14:0] q;
    q = v[34:20];
    if (v[34] && (v[19:0] != 20'd0)) q = q + 15'sd1;
    return clamp_drive(16'(q));
  endfunction

  always_comb begin
    spd    = $signed({7'd0, cfg_i.track_speed, 20'd0});
    prod35 = 35'(prod1_q);
    item2_d.op      = op1_q;
    item2_d.cls     = cls1_q;
    item2_d.cmd     = cmd1_q;
    item2_d.dist_mm = dist1_q;
    item2_d.fwd_a   = scale_drive(spd + prod35);
    item2_d.fwd_b   = scale_drive(spd - prod35);
    item2_d.bwd_a   = scale_drive(-spd + prod35);
    item2_d.bwd_b   = scale_drive(-spd - prod35);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= in_valid_i;
      if (ready2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      op1_q   <= op_i;
      cls1_q  <= cls_d;
      cmd1_q  <= cmd_d;
      dist1_q <= op_i ? dmul[DIST_SHIFT +: DIST_W] : '0;
      prod1_q <= prod_d;
    end
    if (ready2) item2_q <= item2_d;
  end

endmodule

/* design/rhd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_fifo
// Short item queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rhd_fifo import rhd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  rhd_item_t wr_item_i,
  output logic      full_o,
  input  logic      rd_i,
  output rhd_item_t rd_item_o,
  output logic      empty_o
);

  rhd_item_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wp_q, rp_q;
  logic [FIFO_AW:0]     cnt_q;

  assign full_o    = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      if (wr_i && !rd_i) cnt_q <= cnt_q + 1'b1;
      else if (rd_i && !wr_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_item_i;
  end

endmodule

/* design/rhd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_back
// Holds the controller state: line parser, mode, calibration average, drive
// registers. Executes one queued item per cycle into out_q when not stalled.
// ----------------------------------------------------------------------------
module rhd_back import rhd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rhd_cfg_t    cfg_i,
  input  rhd_item_t   item_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rhd_result_t out_o
);

  mode_e                   mode_q, mode_d;
  logic [DIST_W-1:0]       target_q, target_d;
  logic [SUM_W-1:0]        sum_q, sum_d, sum_n;
  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_n;
  cmd_e                    first_q, first_d;
  logic                    started_q, started_d;
  logic signed [DRV_W-1:0] drv_a_q, drv_a_d, drv_b_q, drv_b_d;
  logic                    on_q, on_d;
  logic                    ack, report;
  logic                    out_valid_q;
  rhd_result_t             out_q, res;
  logic [15:0]             band_hi;
  logic signed [16:0]      band_lo;
  logic [SUM_W-1:0]        avg;

  assign pop_o       = !empty_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign sum_n   = sum_q + SUM_W'(item_i.dist_mm);
  assign cnt_n   = cnt_q + 1'b1;
  assign avg     = sum_n / SUM_W'(CALIB_SAMPLES);
  assign band_hi = {1'b0, target_q} + {4'd0, cfg_i.band_tol};
  assign band_lo = $signed({2'b00, target_q}) - $signed({5'd0, cfg_i.band_tol});

  always_comb begin
    mode_d    = mode_q;
    target_d  = target_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    first_d   = first_q;
    started_d = started_q;
    drv_a_d   = drv_a_q;
    drv_b_d   = drv_b_q;
    on_d      = on_q;
    ack       = 1'b0;
    report    = 1'b0;

    if (!item_i.op) begin
      if (item_i.cls == CLS_NEWLINE) begin
        ack       = 1'b1;
        started_d = 1'b0;
        if (started_q) begin
          case (first_q)
            CMD_STANDBY: begin
              mode_d = MODE_STANDBY;
              on_d = 1'b0; drv_a_d = '0; drv_b_d = '0;
            end
            CMD_RELAY: begin
              mode_d = MODE_RELAY;
              on_d = 1'b0; drv_a_d = '0; drv_b_d = '0;
            end
            CMD_TRACK: mode_d = MODE_TRACK;
            CMD_CALIB: begin
              mode_d = MODE_CALIB;
              on_d = 1'b0; drv_a_d = '0; drv_b_d = '0;
              sum_d = '0; cnt_d = '0;
            end
            CMD_ROTATE: begin
              mode_d = MODE_ROTATE;
              on_d = 1'b0; drv_a_d = '0; drv_b_d = '0;
            end
            default: ;
          endcase
        end
      end else if (item_i.cls == CLS_OTHER && !started_q) begin
        first_d   = item_i.cmd;
        started_d = 1'b1;
      end
    end else begin
      case (mode_q)
        MODE_CALIB: begin
          sum_d = sum_n;
          cnt_d = cnt_n;
          if (cnt_n >= CNT_W'(CALIB_SAMPLES)) begin
            target_d = avg[DIST_W-1:0];
            sum_d    = '0;
            cnt_d    = '0;
            mode_d   = MODE_TRACK;
          end
        end
        MODE_RELAY: report = 1'b1;
        MODE_TRACK: begin
          if ({1'b0, item_i.dist_mm} > band_hi) begin
            drv_a_d = item_i.fwd_a; drv_b_d = item_i.fwd_b; on_d = 1'b1;
          end else if ($signed({2'b00, item_i.dist_mm}) < band_lo) begin
            drv_a_d = item_i.bwd_a; drv_b_d = item_i.bwd_b; on_d = 1'b1;
          end else begin
            drv_a_d = '0; drv_b_d = '0; on_d = 1'b0;
          end
        end
        MODE_ROTATE: begin
          drv_a_d = clamp_drive($signed({8'd0, cfg_i.spin_speed}));
          drv_b_d = clamp_drive(-$signed({8'd0, cfg_i.spin_speed}));
          on_d    = 1'b1;
          report  = 1'b1;
        end
        default: ;
      endcase
    end

    res.mode    = mode_d;
    res.drv_a   = drv_a_d;
    res.drv_b   = drv_b_d;
    res.on      = on_d;
    res.dist_mm = item_i.dist_mm;
    res.target  = target_d;
    res.ack     = ack;
    res.report  = report;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CALIB;
      target_q    <= DIST_W'(200);
      sum_q       <= '0;
      cnt_q       <= '0;
      first_q     <= CMD_NONE;
      started_q   <= 1'b0;
      drv_a_q     <= '0;
      drv_b_q     <= '0;
      on_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q      <= mode_d;
        target_q    <= target_d;
        sum_q       <= sum_d;
        cnt_q       <= cnt_d;
        first_q     <= first_d;
        started_q   <= started_d;
        drv_a_q     <= drv_a_d;
        drv_b_q     <= drv_b_d;
        on_q        <= on_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= res;
  end

endmodule

/* design/range_hold_drive_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_hold_drive_controller
// Range-hold drive controller: host command lines and sensor samples in,
// one status item with mode, drives and distances out per input item.
// ----------------------------------------------------------------------------
// Takes one item per clock while the input is ready and returns exactly one
// result item for each, in order; the result passes through two front-end
// stages (byte decode, echo scaling and gyro multiply, then the saturated
// track drives), a four-entry queue, and the back-end state update that
// writes the output register. The input side keeps accepting while a result
// waits on the output, until the queue and front stages are full.
// Configuration writes apply at once and belong to idle periods only.
module range_hold_drive_controller import rhd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // host_byte[7:0], echo_us[23:8], gyro_rate[39:24]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // mode[2:0], motor_a[11:3], motor_b[20:12],
                                      // motor_on[21], distance_mm[36:22],
                                      // target_mm[51:37], line_ack[52],
                                      // report_valid[53], zero[55:54]
);

  rhd_cfg_t    cfg_q;
  logic        q_wr, q_full, q_empty, q_rd;
  rhd_item_t   q_wr_item, q_rd_item;
  rhd_result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.track_speed <= 8'd80;
      cfg_q.band_tol    <= 12'd40;
      cfg_q.spin_speed  <= 8'd100;
      cfg_q.gyro_gain   <= 16'd7314;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRACK_SPEED: cfg_q.track_speed <= cfg_data_i[7:0];
        CFG_BAND_TOL:    cfg_q.band_tol    <= cfg_data_i[11:0];
        CFG_SPIN_SPEED:  cfg_q.spin_speed  <= cfg_data_i[7:0];
        CFG_GYRO_GAIN:   cfg_q.gyro_gain   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rhd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .host_byte_i (s_axis_tdata[7:0]),
    .echo_us_i   (s_axis_tdata[23:8]),
    .gyro_rate_i (s_axis_tdata[39:24]),
    .q_wr_o      (q_wr),
    .q_item_o    (q_wr_item),
    .q_full_i    (q_full)
  );

  rhd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_item_i (q_wr_item),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_item_o (q_rd_item),
    .empty_o   (q_empty)
  );

  rhd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (q_rd_item),
    .empty_i     (q_empty),
    .pop_o       (q_rd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.report, res.ack, res.target, res.dist_mm,
                         res.on, res.drv_b, res.drv_a, res.mode};

endmodule

/* design/rhd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhd_checker
// Port-level checks of the range-hold drive controller, bound to the top.
// ----------------------------------------------------------------------------
module rhd_checker import rhd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_idx_i,
  input logic [15:0] cfg_data_i,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  logic [2:0] mode;
  logic       on, report;
  logic [8:0] mot_a, mot_b;

  assign mode   = m_axis_tdata[2:0];
  assign mot_a  = m_axis_tdata[11:3];
  assign mot_b  = m_axis_tdata[20:12];
  assign on     = m_axis_tdata[21];
  assign report = m_axis_tdata[53];

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // bridge off always comes with zero drives
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !on |-> mot_a == 9'd0 && mot_b == 9'd0)
    else $error("drive nonzero with bridge off");

  // standby, relay and calibrate never drive
  a_idle_modes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode == MODE_STANDBY || mode == MODE_RELAY ||
                      mode == MODE_CALIB) |-> !on)
    else $error("bridge on in a non-driving mode");

  // reports only come out of relay or rotate
  a_report_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && report |-> mode == MODE_RELAY || mode == MODE_ROTATE)
    else $error("report in wrong mode");

endmodule

bind range_hold_drive_controller rhd_checker u_rhd_checker (.*);
